>>> hw/rtl/keyed_quantity_table_unit_macros.svh
// ----------------------------------------------------------------------------
// keyed quantity table assertion macros
// shared concurrent assertion forms, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef KEYED_QUANTITY_TABLE_UNIT_MACROS_SVH
`define KEYED_QUANTITY_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define KQT_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (pre) |-> (post)) else $error("kqt assertion failed");

// next-cycle implication
`define KQT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (pre) |=> (post)) else $error("kqt assertion failed");

`endif

>>> hw/rtl/kqt_pkg.sv
// ----------------------------------------------------------------------------
// kqt_pkg
// types and codes shared by the keyed quantity table unit
// ----------------------------------------------------------------------------
package kqt_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned QtyW = 31;
  localparam int unsigned AmtW = 32;

  // request kinds, the fourth code is unused
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_SHORT    = 3'd3,
    ST_FULL     = 3'd4,
    ST_OVERFLOW = 3'd5
  } kqt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SWEEP,
    S_DECIDE
  } kqt_state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic            cmp;       // latch key match
    logic            sweep;     // advance the hit/quantity chain
    logic            wr_match;  // write qty into the matching cell
    logic            append;    // write key/qty into the first free cell
    logic            shift;     // matching and later cells take from the right
    logic [KeyW-1:0] key;
    logic [QtyW-1:0] qty;
  } kqt_bcast_t;

  // accumulated hit and quantity handed from cell to cell
  typedef struct packed {
    logic            hit;
    logic [QtyW-1:0] qty;
  } kqt_acc_t;

endpackage

>>> hw/rtl/kqt_if.sv
// ----------------------------------------------------------------------------
// kqt request and response channels
// valid/ready channels carrying one request item and one result item
// ----------------------------------------------------------------------------
interface kqt_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic        [31:0] item_key;
  logic signed [31:0] amount;

  modport source (output valid, op, item_key, amount, input ready);
  modport sink   (input valid, op, item_key, amount, output ready);
endinterface

interface kqt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [30:0] quantity;

  modport source (output valid, status, quantity, input ready);
  modport sink   (input valid, status, quantity, output ready);
endinterface

>>> hw/rtl/kqt_cell.sv
// ----------------------------------------------------------------------------
// kqt_cell
// one table slot: holds a key and quantity, matches, accumulates, shifts
// ----------------------------------------------------------------------------
module kqt_cell
  import kqt_pkg::*;
#(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kqt_bcast_t      bcast_i,
  input  logic [CntW-1:0] cnt_i,
  input  logic [KeyW-1:0] nb_key_i,
  input  logic [QtyW-1:0] nb_qty_i,
  input  kqt_acc_t        acc_i,
  output kqt_acc_t        acc_o,
  output logic [KeyW-1:0] key_o,
  output logic [QtyW-1:0] qty_o
);

  logic [KeyW-1:0] key_q;
  logic [QtyW-1:0] qty_q;
  logic            match_q;
  kqt_acc_t        acc_q;
  logic            occupied;
  logic            is_free_slot;

  assign occupied     = CntW'(Idx) < cnt_i;
  assign is_free_slot = CntW'(Idx) == cnt_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      if (bcast_i.cmp) begin
        match_q <= occupied && (key_q == bcast_i.key);
      end
      if (bcast_i.sweep) begin
        acc_q.hit <= acc_i.hit | match_q;
        acc_q.qty <= acc_i.qty | (match_q ? qty_q : '0);
      end
    end
  end

  // acc_q.hit marks this cell as at or after the matching one
  always_ff @(posedge clk_i) begin
    if (bcast_i.shift && acc_q.hit) begin
      key_q <= nb_key_i;
      qty_q <= nb_qty_i;
    end else if (bcast_i.append && is_free_slot) begin
      key_q <= bcast_i.key;
      qty_q <= bcast_i.qty;
    end else if (bcast_i.wr_match && match_q) begin
      qty_q <= bcast_i.qty;
    end
  end

  assign acc_o = acc_q;
  assign key_o = key_q;
  assign qty_o = qty_q;

endmodule

>>> hw/rtl/keyed_quantity_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_quantity_table_unit
// ordered key/quantity table built as a row of cells with add/remove/query
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | handshake
//  req_i   | in  | op, item_key, amount (signed)    | valid/ready
//  rsp_o   | out | status, quantity                 | valid/ready
//
//  an item passes through the idle state that takes it, compare, the
//  sweep steps through the cell chain, then the update
//  and result write
//  the sweep length is set by the hit/quantity chain across the cells
//  rst_ni clears the entry count and control; cell contents need no reset
//  a new item is taken while a result still waits; the update stalls until
//  the output register is free
// ----------------------------------------------------------------------------
module keyed_quantity_table_unit
  import kqt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kqt_req_if.sink   req_i,
  kqt_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  kqt_state_e state_q, state_d;

  // latched request
  logic        [1:0]      op_q;
  logic        [KeyW-1:0] key_q;
  logic signed [AmtW-1:0] amt_q;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] step_q, step_d;

  // result register
  logic            out_valid_q, out_valid_d;
  kqt_status_e     status_q, status_d;
  logic [QtyW-1:0] qty_q, qty_d;

  kqt_bcast_t      bcast;
  kqt_acc_t        acc [TABLE_DEPTH+1];
  logic [KeyW-1:0] cell_key [TABLE_DEPTH];
  logic [QtyW-1:0] cell_qty [TABLE_DEPTH];

  logic            accept;
  logic            out_free;
  logic            found;
  logic [QtyW-1:0] old_qty;
  logic [QtyW-1:0] raw;
  logic            amount_ok;
  logic [QtyW:0]   sum;
  logic [QtyW-1:0] diff;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  // the chain head sees no hit
  assign acc[0] = '0;

  // ---------------- cell row ----------------
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KeyW-1:0] nb_key;
    logic [QtyW-1:0] nb_qty;
    if (i + 1 < TABLE_DEPTH) begin : g_nb
      assign nb_key = cell_key[i+1];
      assign nb_qty = cell_qty[i+1];
    end else begin : g_last
      // last slot takes its own data; it drops out of the count anyway
      assign nb_key = cell_key[i];
      assign nb_qty = cell_qty[i];
    end

    kqt_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .bcast_i  (bcast),
      .cnt_i    (cnt_q),
      .nb_key_i (nb_key),
      .nb_qty_i (nb_qty),
      .acc_i    (acc[i]),
      .acc_o    (acc[i+1]),
      .key_o    (cell_key[i]),
      .qty_o    (cell_qty[i])
    );
  end

  // ---------------- decision terms ----------------
  // at the chain tail: hit anywhere and the matching quantity (0 when absent)
  assign found     = acc[TABLE_DEPTH].hit;
  assign old_qty   = acc[TABLE_DEPTH].qty;
  assign raw       = amt_q[QtyW-1:0];
  assign amount_ok = (amt_q != '0) && !amt_q[AmtW-1];
  assign sum       = {1'b0, old_qty} + {1'b0, raw};
  assign diff      = old_qty - raw;

  // ---------------- state register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.op;
      key_q <= req_i.item_key;
      amt_q <= req_i.amount;
    end
    status_q <= status_d;
    qty_q    <= qty_d;
  end

  // ---------------- next state and outputs ----------------
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    status_d    = status_q;
    qty_d       = qty_q;

    bcast          = '0;
    bcast.key      = key_q;
    bcast.qty      = raw;
    req_i.ready    = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = S_CMP;
        end
      end

      S_CMP: begin
        bcast.cmp = 1'b1;
        step_d    = '0;
        state_d   = S_SWEEP;
      end

      S_SWEEP: begin
        bcast.sweep = 1'b1;
        step_d      = step_q + 1'b1;
        if (step_q == IdxW'(TABLE_DEPTH - 1)) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          status_d    = ST_OK;
          qty_d       = old_qty;
          if (op_q == OP_QUERY) begin
            status_d = ST_OK;
          end else if ((op_q != OP_ADD && op_q != OP_REMOVE) ||
                       key_q == '0 || !amount_ok) begin
            status_d = ST_BAD;
          end else if (op_q == OP_ADD) begin
            if (!found) begin
              if (cnt_q == CntW'(TABLE_DEPTH)) begin
                status_d = ST_FULL;
                qty_d    = '0;
              end else begin
                bcast.append = 1'b1;
                bcast.qty    = raw;
                cnt_d        = cnt_q + 1'b1;
                qty_d        = raw;
              end
            end else if (sum[QtyW]) begin
              status_d = ST_OVERFLOW;
            end else begin
              bcast.wr_match = 1'b1;
              bcast.qty      = sum[QtyW-1:0];
              qty_d          = sum[QtyW-1:0];
            end
          end else begin
            if (!found) begin
              status_d = ST_NOTFOUND;
              qty_d    = '0;
            end else if (old_qty < raw) begin
              status_d = ST_SHORT;
            end else begin
              bcast.wr_match = 1'b1;
              bcast.qty      = diff;
              qty_d          = diff;
              // emptied entry: close the gap from the right
              if (diff == '0) begin
                bcast.shift = 1'b1;
                cnt_d       = cnt_q - 1'b1;
              end
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = status_q;
  assign rsp_o.quantity = qty_q;

  // ---------------- checks ----------------
  `include "keyed_quantity_table_unit_macros.svh"

  `KQT_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CntW'(TABLE_DEPTH))
  `KQT_ASSERT_NEXT(a_cnt_only_decide, state_q != S_DECIDE, $stable(cnt_q))
  `KQT_ASSERT_NEXT(a_accept_to_cmp, accept, state_q == S_CMP)
  `KQT_ASSERT_NEXT(a_stall_holds, state_q == S_DECIDE && !out_free,
                   state_q == S_DECIDE && out_valid_q)

endmodule
